// File: rtl/gtsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtsa_pkg
// Shared types and constants of the generation tagged slot allocator.
// ----------------------------------------------------------------------------
package gtsa_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int GEN_W     = 32;
	localparam int CAP_W     = 7;
	localparam int TIME_W    = 48;
	localparam int TOTAL_W   = 48;
	localparam int SUM_W     = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [1:0] CMD_ACQUIRE  = 2'd0;
	localparam logic [1:0] CMD_RELEASE  = 2'd1;
	localparam logic [1:0] CMD_VALIDATE = 2'd2;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [SLOT_W-1:0] handle_slot;
		logic [GEN_W-1:0]  generation;
		logic [TIME_W-1:0] now_ticks;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  granted_slot;
		logic [GEN_W-1:0]   granted_generation;
		logic [CNT_W-1:0]   busy_count;
		logic [CNT_W-1:0]   peak_busy;
		logic [TOTAL_W-1:0] grant_total;
		logic [TOTAL_W-1:0] reject_total;
		logic [SUM_W-1:0]   lease_time_total;
		logic [TIME_W-1:0]  lease_time_peak;
	} result_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/gtsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtsa_ctrl
// Command sequencer: capture and table read, then one execute cycle.
// ----------------------------------------------------------------------------
module gtsa_ctrl
	import gtsa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output dp_ctrl_t  ctrl
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.execute;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		busy         = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				busy         = 1'b1;
				ctrl.execute = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule
`default_nettype wire

// File: rtl/gtsa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtsa_dp
// Slot tables, free slot search, handle check and statistics counters.
// ----------------------------------------------------------------------------
module gtsa_dp
	import gtsa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_ctrl_t         ctrl,
	input  wire request_t         req,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_data,
	output result_t               res
);

	logic [GEN_W-1:0]  gen_mem  [MAX_SLOTS];
	logic [TIME_W-1:0] time_mem [MAX_SLOTS];

	logic [CAP_W-1:0]     cap_q;
	logic [MAX_SLOTS-1:0] busy_q;
	logic [MAX_SLOTS-1:0] gen_vld_q;
	logic [CNT_W-1:0]     busy_cnt_q;
	logic [CNT_W-1:0]     busy_peak_q;
	logic [TOTAL_W-1:0]   grant_cnt_q;
	logic [TOTAL_W-1:0]   reject_cnt_q;
	logic [SUM_W-1:0]     lease_sum_q;
	logic [TIME_W-1:0]    lease_peak_q;
	result_t              res_q;

	logic [1:0]        cmd_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [GEN_W-1:0]  hgen_s1;
	logic [TIME_W-1:0] now_s1;
	logic              found_s1;
	logic [GEN_W-1:0]  gen_rd_s1;
	logic              gen_vld_s1;
	logic [TIME_W-1:0] time_rd_s1;

	// free slot search
	logic [MAX_SLOTS-1:0] cap_mask;
	logic [MAX_SLOTS-1:0] free_vec;
	logic [MAX_SLOTS-1:0] low_vec;
	logic [SLOT_W-1:0]    free_idx;
	logic [SLOT_W-1:0]    rd_addr;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			cap_mask[i] = CAP_W'(i) < cap_q;
		end
		free_vec = ~busy_q & cap_mask;
		// isolate lowest set bit
		low_vec  = free_vec & (~free_vec + MAX_SLOTS'(1));
		for (int b = 0; b < SLOT_W; b++) begin
			free_idx[b] = 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				if (((i >> b) & 1) == 1) begin
					free_idx[b] = free_idx[b] | low_vec[i];
				end
			end
		end
		rd_addr = (req.command == CMD_ACQUIRE) ? free_idx : req.handle_slot;
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_s1     <= req.command;
			idx_s1     <= rd_addr;
			hgen_s1    <= req.generation;
			now_s1     <= req.now_ticks;
			found_s1   <= |free_vec;
			gen_rd_s1  <= gen_mem[rd_addr];
			gen_vld_s1 <= gen_vld_q[rd_addr];
			time_rd_s1 <= time_mem[rd_addr];
		end
	end

	// execute
	logic [GEN_W-1:0]  gen_cur;
	logic [GEN_W-1:0]  gen_new;
	logic              handle_ok;
	logic              do_grant;
	logic              do_free;
	logic [TIME_W-1:0] lease_dur;
	logic [CNT_W-1:0]  busy_cnt_d;
	logic [CNT_W-1:0]  busy_peak_d;
	logic [TOTAL_W-1:0] grant_cnt_d;
	logic [TOTAL_W-1:0] reject_cnt_d;
	logic [SUM_W-1:0]  lease_sum_d;
	logic [TIME_W-1:0] lease_peak_d;
	logic [1:0]        status_d;

	always_comb begin
		gen_cur   = gen_vld_s1 ? gen_rd_s1 : '0;
		gen_new   = gen_cur + GEN_W'(1);
		handle_ok = (CAP_W'(idx_s1) < cap_q) && busy_q[idx_s1] && (gen_cur == hgen_s1);
		do_grant  = (cmd_s1 == CMD_ACQUIRE) && found_s1;
		do_free   = (cmd_s1 == CMD_RELEASE) && handle_ok;
		lease_dur = now_s1 - time_rd_s1;

		busy_cnt_d   = busy_cnt_q;
		busy_peak_d  = busy_peak_q;
		grant_cnt_d  = grant_cnt_q;
		reject_cnt_d = reject_cnt_q;
		lease_sum_d  = lease_sum_q;
		lease_peak_d = lease_peak_q;
		status_d     = STS_BAD;

		case (cmd_s1)
			CMD_ACQUIRE: begin
				if (found_s1) begin
					busy_cnt_d  = busy_cnt_q + CNT_W'(1);
					grant_cnt_d = grant_cnt_q + TOTAL_W'(1);
					if (busy_cnt_d > busy_peak_q) begin
						busy_peak_d = busy_cnt_d;
					end
					status_d = STS_OK;
				end else begin
					reject_cnt_d = reject_cnt_q + TOTAL_W'(1);
					status_d     = STS_FULL;
				end
			end
			CMD_RELEASE: begin
				if (handle_ok) begin
					if (busy_cnt_q != '0) begin
						busy_cnt_d = busy_cnt_q - CNT_W'(1);
					end
					lease_sum_d = lease_sum_q + SUM_W'(lease_dur);
					if (lease_dur > lease_peak_q) begin
						lease_peak_d = lease_dur;
					end
					status_d = STS_OK;
				end
			end
			CMD_VALIDATE: begin
				if (handle_ok) begin
					status_d = STS_OK;
				end
			end
			default: begin
				status_d = STS_BAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute && do_grant) begin
			gen_mem[idx_s1]  <= gen_new;
			time_mem[idx_s1] <= now_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			busy_q       <= '0;
			gen_vld_q    <= '0;
			busy_cnt_q   <= '0;
			busy_peak_q  <= '0;
			grant_cnt_q  <= '0;
			reject_cnt_q <= '0;
			lease_sum_q  <= '0;
			lease_peak_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (ctrl.execute) begin
				if (do_grant) begin
					busy_q[idx_s1]    <= 1'b1;
					gen_vld_q[idx_s1] <= 1'b1;
				end
				if (do_free) begin
					busy_q[idx_s1] <= 1'b0;
				end
				busy_cnt_q   <= busy_cnt_d;
				busy_peak_q  <= busy_peak_d;
				grant_cnt_q  <= grant_cnt_d;
				reject_cnt_q <= reject_cnt_d;
				lease_sum_q  <= lease_sum_d;
				lease_peak_q <= lease_peak_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			res_q.status             <= status_d;
			res_q.granted_slot       <= do_grant ? idx_s1 : '0;
			res_q.granted_generation <= do_grant ? gen_new : '0;
			res_q.busy_count         <= busy_cnt_d;
			res_q.peak_busy          <= busy_peak_d;
			res_q.grant_total        <= grant_cnt_d;
			res_q.reject_total       <= reject_cnt_d;
			res_q.lease_time_total   <= lease_sum_d;
			res_q.lease_time_peak    <= lease_peak_d;
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

// File: rtl/generation_tagged_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generation_tagged_slot_allocator
// Buffer slot pool with busy flags, generation tags and lease statistics.
// ----------------------------------------------------------------------------
// Usage:
//   request channel: a command (acquire, release, validate) transfers at a
//   rising edge with start high and busy low. Busy is high for the one
//   execute cycle that follows.
//   result channel: done pulses for one cycle with the result on result;
//   both are registered from the execute state. The receiver cannot stall.
//   config channel: cfg_valid/cfg_ready write the slot capacity; cfg_ready
//   is always high. Write it only while no command is in flight.
// Sequence: a new command is not taken while busy is high. The capture
//   step reads the table entry chosen by the free slot search or the
//   handle; the execute step checks it, updates the tables and counters.
// Reset: busy flags, generation valid bits and all counters clear at once;
//   capacity returns to 64. No clearing pass; the block is ready at once.
// ----------------------------------------------------------------------------
module generation_tagged_slot_allocator
	import gtsa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire request_t         request,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data
);

	dp_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	gtsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	gtsa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.req      (request),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.res      (result)
	);

	// a transfer leads to exactly one execute cycle, then the result strobe
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("execute cycle missing after transfer");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("result strobe missing after execute");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.busy_count <= CNT_W'(MAX_SLOTS)
			&& result.peak_busy >= result.busy_count))
		else $error("busy count out of range");

endmodule
`default_nettype wire
